// ----- hdl/epcd_pkg.sv -----
// Package for the epoch to calendar date converter: constants, types and month table.
`timescale 1ns / 1ps
`default_nettype none

package epcd_pkg;

	localparam int SubWidth = 18;
	typedef logic [SubWidth-1:0] sub_t;

	localparam int RecipWidth = 26;
	typedef logic [RecipWidth-1:0] recip_t;

	localparam sub_t SecsPerDay  = 18'd86400;
	localparam sub_t SecsPerHour = 18'd3600;
	localparam sub_t SecsPerMin  = 18'd60;
	localparam sub_t DaysLeap    = 18'd366;
	localparam sub_t DaysCommon  = 18'd365;

	// rounded-up reciprocals of 675, 225 and 15, quotient at bit 35, 21 and 14
	localparam recip_t RecipDay  = 26'd50903317;
	localparam recip_t RecipHour = 26'd9321;
	localparam recip_t RecipMin  = 26'd1093;

	// 1970 taken modulo 4, 100 and 400
	localparam logic [1:0] EpochMod4   = 2'd2;
	localparam logic [6:0] EpochMod100 = 7'd70;
	localparam logic [8:0] EpochMod400 = 9'd370;

	localparam logic [7:0] YearLimit = 8'd255;
	localparam logic [3:0] MonthDec  = 4'd11;
	localparam logic [3:0] MonthFeb  = 4'd1;

	// month index from 0
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			4'd1: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/epoch_to_calendar_date.sv -----
// Epoch to calendar date converter: top level with sequencer, shared multiplier and subtractor.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month and years since 1970 (full Gregorian leap rule).
// One 25 x 26 multiplier and one 18-bit subtract and compare unit do all the work: each
// division by 86400, 3600 and 60 is a rounded-up reciprocal multiply, a multiply back and
// a subtract for the remainder, then one year length per cycle and one month length per
// cycle. A finished result waits in the final state while the output register holds a
// stalled result. The next word can be accepted in the cycle after the result is written.
// One word is in work at a time; a finished result sits in the output register while the
// next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module epoch_to_calendar_date (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] epoch_seconds,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       second_of_minute,
	output logic [5:0]       minute_of_hour,
	output logic [4:0]       hour_of_day,
	output logic [4:0]       day_of_month,
	output logic [3:0]       month_of_year,
	output logic [7:0]       years_since_1970
);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_YEAR, ST_MONTH, ST_FIN} state_t;
	typedef enum logic [1:0] {PH_DAY, PH_HOUR, PH_MIN} phase_t;
	typedef enum logic [1:0] {SU_RECIP, SU_BACK, SU_REM} step_t;

	state_t      state_q;
	phase_t      phase_q;
	step_t       step_q;
	logic [16:0] acc_q;
	logic [31:0] dvd_q;
	logic [50:0] prod_q;
	logic [15:0] days_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [7:0]  yr_q;
	logic [3:0]  month_q;
	logic [1:0]  mod4_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;

	logic                out_valid_q;
	logic [5:0]          out_sec_q;
	logic [5:0]          out_min_q;
	logic [4:0]          out_hour_q;
	logic [4:0]          out_day_q;
	logic [3:0]          out_month_q;
	logic [7:0]          out_year_q;

	epcd_pkg::sub_t      sub_a;
	epcd_pkg::sub_t      sub_b;
	epcd_pkg::sub_t      divisor;
	epcd_pkg::recip_t    recip;
	logic [epcd_pkg::SubWidth:0] diff;
	logic                fits;
	logic                leap;
	logic [24:0]         scaled;
	logic [15:0]         quot;
	logic [16:0]         rem_src;
	logic [24:0]         mul_a;
	logic [25:0]         mul_b;
	logic [50:0]         product;
	logic                in_acc;
	logic                out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

	always_comb begin
		case (phase_q)
			PH_DAY: begin
				divisor = epcd_pkg::SecsPerDay;
				recip   = epcd_pkg::RecipDay;
				scaled  = dvd_q[31:7];
				quot    = prod_q[50:35];
				rem_src = dvd_q[16:0];
			end
			PH_HOUR: begin
				divisor = epcd_pkg::SecsPerHour;
				recip   = epcd_pkg::RecipHour;
				scaled  = {12'd0, acc_q[16:4]};
				quot    = prod_q[36:21];
				rem_src = acc_q;
			end
			default: begin
				divisor = epcd_pkg::SecsPerMin;
				recip   = epcd_pkg::RecipMin;
				scaled  = {15'd0, acc_q[11:2]};
				quot    = prod_q[29:14];
				rem_src = acc_q;
			end
		endcase
	end

	// shared multiplier: reciprocal first, then quotient times divisor
	assign mul_a   = (step_q == SU_RECIP) ? scaled : {9'd0, quot};
	assign mul_b   = (step_q == SU_RECIP) ? recip : {8'd0, divisor};
	assign product = mul_a * mul_b;

	always_comb begin
		case (state_q)
			ST_DIV: begin
				sub_a = {1'b0, rem_src};
				sub_b = {1'b0, prod_q[16:0]};
			end
			ST_YEAR: begin
				sub_a = {2'b00, days_q};
				sub_b = leap ? epcd_pkg::DaysLeap : epcd_pkg::DaysCommon;
			end
			default: begin
				sub_a = {2'b00, days_q};
				sub_b = {13'd0, epcd_pkg::month_len(month_q, leap)};
			end
		endcase
	end

	// shared subtract and compare; remainders are taken modulo 2^17
	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign fits = !diff[epcd_pkg::SubWidth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_DAY;
			step_q      <= SU_RECIP;
			acc_q       <= '0;
			dvd_q       <= '0;
			prod_q      <= '0;
			days_q      <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			yr_q        <= '0;
			month_q     <= '0;
			mod4_q      <= '0;
			mod100_q    <= '0;
			mod400_q    <= '0;
			out_valid_q <= 1'b0;
			out_sec_q   <= '0;
			out_min_q   <= '0;
			out_hour_q  <= '0;
			out_day_q   <= '0;
			out_month_q <= '0;
			out_year_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						dvd_q   <= epoch_seconds;
						phase_q <= PH_DAY;
						step_q  <= SU_RECIP;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					case (step_q)
						SU_RECIP: begin
							prod_q <= product;
							step_q <= SU_BACK;
						end
						SU_BACK: begin
							prod_q <= product;
							step_q <= SU_REM;
							case (phase_q)
								PH_DAY:  days_q <= quot;
								PH_HOUR: hour_q <= quot[4:0];
								default: min_q  <= quot[5:0];
							endcase
						end
						default: begin
							step_q <= SU_RECIP;
							case (phase_q)
								PH_DAY: begin
									acc_q   <= diff[16:0];
									phase_q <= PH_HOUR;
								end
								PH_HOUR: begin
									acc_q   <= diff[16:0];
									phase_q <= PH_MIN;
								end
								default: begin
									sec_q    <= diff[5:0];
									yr_q     <= '0;
									mod4_q   <= epcd_pkg::EpochMod4;
									mod100_q <= epcd_pkg::EpochMod100;
									mod400_q <= epcd_pkg::EpochMod400;
									phase_q  <= PH_DAY;
									state_q  <= ST_YEAR;
								end
							endcase
						end
					endcase
				end
				ST_YEAR: begin
					if (fits && (yr_q != epcd_pkg::YearLimit)) begin
						days_q   <= diff[15:0];
						yr_q     <= yr_q + 8'd1;
						mod4_q   <= mod4_q + 2'd1;
						mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
						mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
					end else begin
						month_q <= '0;
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (fits && (month_q != epcd_pkg::MonthDec)) begin
						days_q  <= diff[15:0];
						month_q <= month_q + 4'd1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_sec_q   <= sec_q;
						out_min_q   <= min_q;
						out_hour_q  <= hour_q;
						out_day_q   <= days_q[4:0] + 5'd1;
						out_month_q <= month_q + 4'd1;
						out_year_q  <= yr_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign second_of_minute = out_sec_q;
	assign minute_of_hour   = out_min_q;
	assign hour_of_day      = out_hour_q;
	assign day_of_month     = out_day_q;
	assign month_of_year    = out_month_q;
	assign years_since_1970 = out_year_q;

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DIV) && (phase_q == PH_DAY) && (step_q == SU_RECIP))
		else $error("accepted word did not start the division");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the final step");

	a_month_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (month_q <= epcd_pkg::MonthDec))
		else $error("month index past December");

	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (days_q <= 16'd30))
		else $error("day remainder too large at the end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(out_day_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- verif/epoch_to_calendar_date_tb.sv -----
// Self-checking testbench for the epoch to calendar date converter.
`timescale 1ns / 1ps

module epoch_to_calendar_date_tb;

	localparam int IdleLimit = 10000;
	localparam int DrainCycles = 250;
	localparam int PhaseWords = 160;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] mday;
		logic [3:0] mon;
		logic [7:0] year;
	} date_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [4:0]  day_of_month;
	logic [3:0]  month_of_year;
	logic [7:0]  years_since_1970;

	int tx_idle_pct;
	int rx_idle_pct;
	int stuck_cycles;

	function automatic bit is_leap_offset(int unsigned yoff);
		int unsigned y;
		y = 1970 + yoff;
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned yoff);
		int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 1 && is_leap_offset(yoff))
			return 29;
		return lens[m];
	endfunction

	function automatic date_t calendar_date(logic [31:0] s);
		date_t d;
		int unsigned days;
		int unsigned yr;
		int unsigned mo;
		int unsigned ylen;
		int unsigned mlen;
		d.sec  = 6'(s % 60);
		d.min  = 6'((s % 3600) / 60);
		d.hour = 5'((s % 86400) / 3600);
		days = s / 86400;
		yr = 0;
		mo = 0;
		while (1) begin
			ylen = is_leap_offset(yr) ? 366 : 365;
			if (days < ylen || yr >= 255)
				break;
			days -= ylen;
			yr++;
		end
		while (mo < 11) begin
			mlen = days_in_month(mo, yr);
			if (days < mlen)
				break;
			days -= mlen;
			mo++;
		end
		d.mday = 5'(days + 1);
		d.mon  = 4'(mo + 1);
		d.year = 8'(yr);
		return d;
	endfunction

	class date_scoreboard;
		date_t pending[$];
		int errors;
		int checked;
		int leap_days;
		int max_year;

		function void note_epoch(logic [31:0] s);
			pending.push_back(calendar_date(s));
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_date(date_t got);
			date_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			want = pending.pop_front();
			check_field("second_of_minute", want.sec, got.sec);
			check_field("minute_of_hour", want.min, got.min);
			check_field("hour_of_day", want.hour, got.hour);
			check_field("day_of_month", want.mday, got.mday);
			check_field("month_of_year", want.mon, got.mon);
			check_field("years_since_1970", want.year, got.year);
			checked++;
			if (want.mon == 2 && want.mday == 29)
				leap_days++;
			if (want.year > max_year)
				max_year = want.year;
		endfunction
	endclass

	date_scoreboard sb = new;

	epoch_to_calendar_date uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.second_of_minute(second_of_minute),
		.minute_of_hour(minute_of_hour),
		.hour_of_day(hour_of_day),
		.day_of_month(day_of_month),
		.month_of_year(month_of_year),
		.years_since_1970(years_since_1970)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_epoch(epoch_seconds);
		if (out_valid && !out_stall)
			sb.check_date({second_of_minute, minute_of_hour, hour_of_day,
				day_of_month, month_of_year, years_since_1970});
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= IdleLimit) begin
			$display("epoch_to_calendar_date_tb failed");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_word(logic [31:0] v);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		epoch_seconds = v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	function automatic int unsigned days_to_year(int unsigned yoff);
		int unsigned n;
		n = 0;
		for (int unsigned y = 0; y < yoff; y++)
			n += is_leap_offset(y) ? 366 : 365;
		return n;
	endfunction

	function automatic logic [31:0] random_epoch();
		int unsigned d;
		int unsigned y;
		int unsigned m;
		longint t;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				d = $urandom_range(0, 49709);
				case ($urandom_range(0, 3))
					0: return d * 86400;
					1: return d * 86400 + 1;
					2: return d * 86400 + 86399;
					default: return d * 86400 + $urandom_range(0, 86399);
				endcase
			end
			default: begin
				// near a month or year start
				y = $urandom_range(0, 136);
				m = $urandom_range(0, 11);
				d = days_to_year(y);
				for (int unsigned k = 0; k < m; k++)
					d += days_in_month(k, y);
				t = longint'(d) * 86400;
				case ($urandom_range(0, 3))
					0: t = t - 1;
					1: t = t + 1;
					2: t = t + 86399;
					default: ;
				endcase
				if (t < 0)
					t = 0;
				if (t > 64'hFFFF_FFFF)
					t = 64'hFFFF_FFFF - $urandom_range(0, 100000);
				return t[31:0];
			end
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		directed = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
			32'd86399, 32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
			32'd68256000, 32'd951782400, 32'd978220800, 32'd2147483647,
			32'h8000_0000, 32'd4107456000, 32'd4107542400, 32'd4291747199,
			32'd4291747200, 32'hAAAA_AAAA, 32'h5555_5555};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 21;
		rx_idle_pct = 73;
		foreach (directed[i])
			send_word(directed[i]);
		for (int i = 0; i < PhaseWords; i++)
			send_word(random_epoch());
		wait_drained();

		tx_idle_pct = 73;
		rx_idle_pct = 21;
		for (int i = 0; i < PhaseWords; i++)
			send_word(random_epoch());
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < PhaseWords; i++)
			send_word(random_epoch());
		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("checked %0d dates from 1970 through year offset %0d, %0d on a leap day",
			sb.checked, sb.max_year, sb.leap_days);
		$display("sender and receiver stalls swapped between phases, last phase at full rate");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("epoch_to_calendar_date_tb passed");
		else
			$display("epoch_to_calendar_date_tb failed");
		$finish;
	end

endmodule
